// File: sv/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest core package
// Shared widths, constants and the sequencer state type of the digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

  localparam logic [6:0] ROUND_20   = 7'd20;
  localparam logic [6:0] ROUND_40   = 7'd40;
  localparam logic [6:0] ROUND_60   = 7'd60;
  localparam logic [6:0] ROUND_LAST = 7'd79;

  localparam logic [5:0] POS_LEN  = 6'd56;
  localparam logic [5:0] POS_LAST = 6'd63;

  localparam logic [BYTE_W-1:0] PAD_MARK     = 8'h80;
  localparam logic [LEN_W-1:0]  DIGEST_BYTES = 5'd20;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

// File: sv/sha1md_feed_if.sv
// ----------------------------------------------------------------------------
// SHA-1 message channel
// Carries one message byte per word, with its presence and end-of-message flags.
// ----------------------------------------------------------------------------
interface sha1md_feed_if;
  logic                          valid;
  logic                          ready;
  logic [sha1md_pkg::BYTE_W-1:0] data_byte;
  logic                          has_byte;
  logic                          last_byte;

  modport source (output valid, data_byte, has_byte, last_byte, input ready);
  modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

// File: sv/sha1md_result_if.sv
// ----------------------------------------------------------------------------
// SHA-1 digest channel
// Carries one digest byte per word, flagged on the final byte of a digest.
// ----------------------------------------------------------------------------
interface sha1md_result_if;
  logic                          valid;
  logic                          ready;
  logic [sha1md_pkg::BYTE_W-1:0] digest_byte;
  logic                          last_of_digest;

  modport source (output valid, digest_byte, last_of_digest, input ready);
  modport sink (input valid, digest_byte, last_of_digest, output ready);
endinterface

// File: sv/sha1_message_digest_core.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Byte-serial SHA-1 with one shared round unit and a one-hot sequencer.
// ----------------------------------------------------------------------------
// The feed channel takes one message byte per word. A word with has_byte low
// carries no byte; a word with last_byte high ends the message. The result
// channel then gives the leading digest_length bytes of the digest (values
// above 20 act as 20), the last one flagged by last_of_digest.
// Bytes are taken at one per cycle while a block fills. The byte that
// completes a 64-byte block starts a compression (80 rounds of the single
// round unit plus one chaining-word addition; the working words are loaded
// as that byte is stored), during which feed.ready is low.
// At the end of a message the padding goes in at one byte per cycle (up to
// 72 bytes) with one or two compressions, after which the digest bytes leave
// at one per cycle through an output register while the receiver takes them.
// The feed side is accepted whilst an earlier digest byte still waits in the
// output register; a stalled receiver holds the digest emission only.
// Reset loads the standard initial chaining words, clears the bit count, sets
// digest_length to 20. The block buffer is not cleared. digest_length must be
// written through cfg_we/cfg_wdata only while the core is idle (not enforced).
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sha1md_pkg::LEN_W-1:0] cfg_wdata,
  sha1md_feed_if.sink                  feed,
  sha1md_result_if.source              result
);
  import sha1md_pkg::*;

  state_t                state;
  logic [31:0]           h0, h1, h2, h3, h4;
  logic [31:0]           a, b, c, d, e;
  logic [511:0]          msg;
  logic [63:0]           bit_count;
  logic [63:0]           msg_len;
  logic [6:0]            rnd;
  logic [LEN_W-1:0]      digest_length;
  logic [LEN_W-1:0]      emit_idx;
  logic                  finishing;
  logic                  mark_done;
  logic                  len_phase;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;

  logic                  feed_fire;
  logic [5:0]            pos;
  logic [63:0]           bit_count_next;
  logic [BYTE_W-1:0]     len_byte;
  logic [BYTE_W-1:0]     pad_byte;
  logic                  put_en;
  logic [BYTE_W-1:0]     put_val;
  logic [31:0]           f_val;
  logic [31:0]           k_val;
  logic [31:0]           t_val;
  logic [31:0]           w_mix;
  logic [31:0]           w_new;
  logic [LEN_W-1:0]      n_bytes;
  logic                  out_free;
  logic [159:0]          digest_vec;
  logic [BYTE_W-1:0]     dig_bytes [DIGEST_BYTES];

  assign feed.ready            = (state == ST_IDLE);
  assign feed_fire             = feed.valid && feed.ready;
  assign result.valid          = out_valid;
  assign result.digest_byte    = out_byte;
  assign result.last_of_digest = out_last;

  assign pos            = bit_count[8:3];
  assign bit_count_next = bit_count + 64'd8;
  assign len_byte       = BYTE_W'(msg_len >> {~pos[2:0], 3'b000});
  assign n_bytes        = (digest_length > DIGEST_BYTES) ? DIGEST_BYTES : digest_length;
  assign out_free       = !out_valid || result.ready;
  assign digest_vec     = {h0, h1, h2, h3, h4};

  for (genvar gi = 0; gi < DIGEST_BYTES; gi++) begin : g_dig
    assign dig_bytes[gi] = digest_vec[159 - 8 * gi -: 8];
  end

  always_comb begin
    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (len_phase || pos == POS_LEN) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
    put_en  = (feed_fire && feed.has_byte) || (state == ST_PAD);
    put_val = (state == ST_PAD) ? pad_byte : feed.data_byte;
  end

  always_comb begin
    if (rnd < ROUND_20) begin
      f_val = (b & c) | (~b & d);
      k_val = K_CH;
    end else if (rnd < ROUND_40) begin
      f_val = b ^ c ^ d;
      k_val = K_PA1;
    end else if (rnd < ROUND_60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K_MAJ;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K_PA2;
    end
    t_val = {a[26:0], a[31:27]} + f_val + e + k_val + msg[511:480];
    w_mix = msg[95:64] ^ msg[255:224] ^ msg[447:416] ^ msg[511:480];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      h0            <= H0_INIT;
      h1            <= H1_INIT;
      h2            <= H2_INIT;
      h3            <= H3_INIT;
      h4            <= H4_INIT;
      bit_count     <= '0;
      digest_length <= DIGEST_BYTES;
      finishing     <= 1'b0;
      mark_done     <= 1'b0;
      len_phase     <= 1'b0;
      out_valid     <= 1'b0;
      rnd           <= '0;
      emit_idx      <= '0;
    end else begin
      if (cfg_we) begin
        digest_length <= cfg_wdata;
      end
      if (out_valid && result.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      if (put_en) begin
        msg       <= {msg[503:0], put_val};
        bit_count <= bit_count_next;
        if (pos == POS_LAST) begin
          a   <= h0;
          b   <= h1;
          c   <= h2;
          d   <= h3;
          e   <= h4;
          rnd <= '0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (feed_fire) begin
            if (feed.last_byte) begin
              finishing <= 1'b1;
              mark_done <= 1'b0;
              len_phase <= 1'b0;
              msg_len   <= feed.has_byte ? bit_count_next : bit_count;
            end
            if (feed.has_byte && pos == POS_LAST) begin
              state <= ST_ROUND;
            end else if (feed.last_byte) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          mark_done <= 1'b1;
          if (mark_done && pos == POS_LEN) begin
            len_phase <= 1'b1;
          end
          if (pos == POS_LAST) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          a   <= t_val;
          b   <= a;
          c   <= {b[1:0], b[31:2]};
          d   <= c;
          e   <= d;
          msg <= {msg[479:0], w_new};
          rnd <= rnd + 7'd1;
          if (rnd == ROUND_LAST) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (len_phase && n_bytes == '0) begin
            h0        <= H0_INIT;
            h1        <= H1_INIT;
            h2        <= H2_INIT;
            h3        <= H3_INIT;
            h4        <= H4_INIT;
            bit_count <= '0;
            finishing <= 1'b0;
            len_phase <= 1'b0;
            state     <= ST_IDLE;
          end else begin
            h0 <= h0 + a;
            h1 <= h1 + b;
            h2 <= h2 + c;
            h3 <= h3 + d;
            h4 <= h4 + e;
            if (len_phase) begin
              emit_idx <= '0;
              state    <= ST_EMIT;
            end else if (finishing) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= dig_bytes[emit_idx];
            out_last  <= (emit_idx == n_bytes - LEN_W'(1));
            emit_idx  <= emit_idx + LEN_W'(1);
            if (emit_idx == n_bytes - LEN_W'(1)) begin
              h0        <= H0_INIT;
              h1        <= H1_INIT;
              h2        <= H2_INIT;
              h3        <= H3_INIT;
              h4        <= H4_INIT;
              bit_count <= '0;
              finishing <= 1'b0;
              len_phase <= 1'b0;
              state     <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (rnd <= ROUND_LAST))
    else $error("Round counter ran past the final round.");

  a_add_after_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD) |-> $past(state == ST_ROUND && rnd == ROUND_LAST))
    else $error("Chaining addition entered before all rounds completed.");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_idx < n_bytes))
    else $error("Digest byte index beyond the requested length.");

  a_no_feed_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND || state == ST_PAD) |-> !feed.ready)
    else $error("Feed channel ready during compression or padding.");

endmodule
